// ===== hdl/sc2a_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc2a_pkg
// Shared types, constants and the set-1 keymap tables of the scancode
// to ASCII translator with its character queue.
// ----------------------------------------------------------------------------
package sc2a_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam int         SC_BREAK_BIT    = 7;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_PUSH,
    CMD_READ
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [6:0] ch;
  } cmd_t;

  function automatic logic [6:0] plain_char(input logic [6:0] code);
    logic [6:0] c;
    c = 7'h00;
    case (code)
      7'd1:  c = 7'h1B;
      7'd2:  c = 7'h31;
      7'd3:  c = 7'h32;
      7'd4:  c = 7'h33;
      7'd5:  c = 7'h34;
      7'd6:  c = 7'h35;
      7'd7:  c = 7'h36;
      7'd8:  c = 7'h37;
      7'd9:  c = 7'h38;
      7'd10: c = 7'h39;
      7'd11: c = 7'h30;
      7'd12: c = 7'h2D;
      7'd13: c = 7'h3D;
      7'd14: c = 7'h08;
      7'd15: c = 7'h09;
      7'd16: c = 7'h71;
      7'd17: c = 7'h77;
      7'd18: c = 7'h65;
      7'd19: c = 7'h72;
      7'd20: c = 7'h74;
      7'd21: c = 7'h79;
      7'd22: c = 7'h75;
      7'd23: c = 7'h69;
      7'd24: c = 7'h6F;
      7'd25: c = 7'h70;
      7'd26: c = 7'h5B;
      7'd27: c = 7'h5D;
      7'd28: c = 7'h0A;
      7'd30: c = 7'h61;
      7'd31: c = 7'h73;
      7'd32: c = 7'h64;
      7'd33: c = 7'h66;
      7'd34: c = 7'h67;
      7'd35: c = 7'h68;
      7'd36: c = 7'h6A;
      7'd37: c = 7'h6B;
      7'd38: c = 7'h6C;
      7'd39: c = 7'h3B;
      7'd40: c = 7'h27;
      7'd41: c = 7'h60;
      7'd43: c = 7'h5C;
      7'd44: c = 7'h7A;
      7'd45: c = 7'h78;
      7'd46: c = 7'h63;
      7'd47: c = 7'h76;
      7'd48: c = 7'h62;
      7'd49: c = 7'h6E;
      7'd50: c = 7'h6D;
      7'd51: c = 7'h2C;
      7'd52: c = 7'h2E;
      7'd53: c = 7'h2F;
      7'd55: c = 7'h2A;
      7'd57: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] shifted_char(input logic [6:0] code);
    logic [6:0] c;
    c = 7'h00;
    case (code)
      7'd1:  c = 7'h1B;
      7'd2:  c = 7'h21;
      7'd3:  c = 7'h40;
      7'd4:  c = 7'h23;
      7'd5:  c = 7'h24;
      7'd6:  c = 7'h25;
      7'd7:  c = 7'h5E;
      7'd8:  c = 7'h26;
      7'd9:  c = 7'h2A;
      7'd10: c = 7'h28;
      7'd11: c = 7'h29;
      7'd12: c = 7'h5F;
      7'd13: c = 7'h2B;
      7'd14: c = 7'h08;
      7'd15: c = 7'h09;
      7'd16: c = 7'h51;
      7'd17: c = 7'h57;
      7'd18: c = 7'h45;
      7'd19: c = 7'h52;
      7'd20: c = 7'h54;
      7'd21: c = 7'h59;
      7'd22: c = 7'h55;
      7'd23: c = 7'h49;
      7'd24: c = 7'h4F;
      7'd25: c = 7'h50;
      7'd26: c = 7'h7B;
      7'd27: c = 7'h7D;
      7'd28: c = 7'h0A;
      7'd30: c = 7'h41;
      7'd31: c = 7'h53;
      7'd32: c = 7'h44;
      7'd33: c = 7'h46;
      7'd34: c = 7'h47;
      7'd35: c = 7'h48;
      7'd36: c = 7'h4A;
      7'd37: c = 7'h4B;
      7'd38: c = 7'h4C;
      7'd39: c = 7'h3A;
      7'd40: c = 7'h22;
      7'd41: c = 7'h7E;
      7'd43: c = 7'h7C;
      7'd44: c = 7'h5A;
      7'd45: c = 7'h58;
      7'd46: c = 7'h43;
      7'd47: c = 7'h56;
      7'd48: c = 7'h42;
      7'd49: c = 7'h4E;
      7'd50: c = 7'h4D;
      7'd51: c = 7'h3C;
      7'd52: c = 7'h3E;
      7'd53: c = 7'h3F;
      7'd55: c = 7'h2A;
      7'd57: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/sc2a_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc2a channel interfaces
// Request channel (scancode byte or read) and response channel of the
// translator, each with valid/ready and its payload.
// ----------------------------------------------------------------------------
interface sc2a_req_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] scancode;
  logic       from_aux;

  modport source (output valid, output opcode, output scancode, output from_aux,
                  input ready);
  modport sink   (input valid, input opcode, input scancode, input from_aux,
                  output ready);
endinterface

interface sc2a_rsp_if;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [6:0] char_value;
  logic       char_pushed;
  logic       char_dropped;

  modport source (output valid, output char_valid, output char_value,
                  output char_pushed, output char_dropped, input ready);
  modport sink   (input valid, input char_valid, input char_value,
                  input char_pushed, input char_dropped, output ready);
endinterface

// ===== hdl/sc2a_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc2a_front
// Classifies each request: tracks the shift keys, drops aux and break
// bytes, translates make codes and emits a queue command.
// ----------------------------------------------------------------------------
module sc2a_front (
  input  logic            clk,
  input  logic            rst,
  sc2a_req_if.sink        req,
  output logic            cmd_valid,
  output sc2a_pkg::cmd_t  cmd,
  input  logic            cmd_ready
);

  logic       shift_held;
  logic       shift_held_next;
  logic [6:0] ch;

  assign req.ready = cmd_ready;
  assign cmd_valid = req.valid;

  always_comb begin
    ch = shift_held ? sc2a_pkg::shifted_char(req.scancode[6:0])
                    : sc2a_pkg::plain_char(req.scancode[6:0]);
  end

  always_comb begin
    cmd.op          = sc2a_pkg::CMD_NONE;
    cmd.ch          = ch;
    shift_held_next = shift_held;
    if (req.opcode == sc2a_pkg::OP_READ) begin
      cmd.op = sc2a_pkg::CMD_READ;
    end else if (!req.from_aux) begin
      if (req.scancode == sc2a_pkg::SC_LSHIFT_MAKE ||
          req.scancode == sc2a_pkg::SC_RSHIFT_MAKE) begin
        shift_held_next = 1'b1;
      end else if (req.scancode == sc2a_pkg::SC_LSHIFT_BREAK ||
                   req.scancode == sc2a_pkg::SC_RSHIFT_BREAK) begin
        shift_held_next = 1'b0;
      end else if (!req.scancode[sc2a_pkg::SC_BREAK_BIT] && ch != 7'h00) begin
        cmd.op = sc2a_pkg::CMD_PUSH;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= 1'b0;
    end else if (req.valid && req.ready) begin
      shift_held <= shift_held_next;
    end
  end

endmodule

// ===== hdl/sc2a_cmd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc2a_cmd_queue
// Short command queue between the classifier and the character store,
// letting either side stall on its own.
// ----------------------------------------------------------------------------
module sc2a_cmd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  sc2a_pkg::cmd_t  in_cmd,
  output logic            in_ready,
  output logic            out_valid,
  output sc2a_pkg::cmd_t  out_cmd,
  input  logic            out_ready
);

  sc2a_pkg::cmd_t                 entries [sc2a_pkg::CQ_DEPTH];
  logic [sc2a_pkg::CQ_PTR_W-1:0]  wr_idx;
  logic [sc2a_pkg::CQ_PTR_W-1:0]  rd_idx;
  logic [sc2a_pkg::CQ_CNT_W-1:0]  count;
  logic                           push;
  logic                           pop;

  function automatic logic [sc2a_pkg::CQ_PTR_W-1:0] bump(
    input logic [sc2a_pkg::CQ_PTR_W-1:0] p);
    return (p == sc2a_pkg::CQ_PTR_W'(sc2a_pkg::CQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_ready  = (count != sc2a_pkg::CQ_CNT_W'(sc2a_pkg::CQ_DEPTH));
  assign out_valid = (count != '0);
  assign out_cmd   = entries[rd_idx];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_idx] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_idx <= bump(wr_idx);
      end
      if (pop) begin
        rd_idx <= bump(rd_idx);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/sc2a_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc2a_back
// Character ring buffer (one slot kept empty) with registered read, and
// the output register that holds each response.
// ----------------------------------------------------------------------------
module sc2a_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  sc2a_pkg::cmd_t  cmd,
  output logic            cmd_ready,
  sc2a_rsp_if.source      rsp
);

  logic [6:0]                  char_store [sc2a_pkg::QUEUE_DEPTH];
  logic [sc2a_pkg::PTR_W-1:0]  write_pointer;
  logic [sc2a_pkg::PTR_W-1:0]  read_pointer;
  logic [sc2a_pkg::PTR_W-1:0]  write_pointer_next;
  logic [sc2a_pkg::PTR_W-1:0]  read_pointer_next;
  logic                        empty;
  logic                        full;
  logic                        adv;
  logic                        do_push;
  logic                        do_pop;
  logic                        do_drop;
  logic                        out_valid;
  logic                        out_char_valid;
  logic                        out_pushed;
  logic                        out_dropped;
  logic [6:0]                  rdata;

  function automatic logic [sc2a_pkg::PTR_W-1:0] bump(
    input logic [sc2a_pkg::PTR_W-1:0] p);
    return (p == sc2a_pkg::PTR_W'(sc2a_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign write_pointer_next = bump(write_pointer);
  assign read_pointer_next  = bump(read_pointer);
  assign empty = (read_pointer == write_pointer);
  assign full  = (write_pointer_next == read_pointer);

  assign cmd_ready = !out_valid || rsp.ready;
  assign adv       = cmd_valid && cmd_ready;

  always_comb begin
    do_push = 1'b0;
    do_pop  = 1'b0;
    do_drop = 1'b0;
    unique case (cmd.op)
      sc2a_pkg::CMD_PUSH: begin
        do_push = !full;
        do_drop = full;
      end
      sc2a_pkg::CMD_READ: begin
        do_pop = !empty;
      end
      sc2a_pkg::CMD_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // store write and registered read; a pop never targets the slot being written
  always_ff @(posedge clk) begin
    if (adv && do_push) begin
      char_store[write_pointer] <= cmd.ch;
    end
    if (adv && do_pop) begin
      rdata <= char_store[read_pointer];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer  <= '0;
      read_pointer   <= '0;
      out_valid      <= 1'b0;
      out_char_valid <= 1'b0;
      out_pushed     <= 1'b0;
      out_dropped    <= 1'b0;
    end else if (adv) begin
      out_valid      <= 1'b1;
      out_char_valid <= do_pop;
      out_pushed     <= do_push;
      out_dropped    <= do_drop;
      if (do_push) begin
        write_pointer <= write_pointer_next;
      end
      if (do_pop) begin
        read_pointer <= read_pointer_next;
      end
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.char_valid   = out_char_valid;
  assign rsp.char_value   = out_char_valid ? rdata : 7'h00;
  assign rsp.char_pushed  = out_pushed;
  assign rsp.char_dropped = out_dropped;

endmodule

// ===== hdl/scancode_to_ascii_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_to_ascii_queue
// Set-1 scancode to ASCII translator feeding a character ring buffer
// that is drained by read requests.
// ----------------------------------------------------------------------------
// path: a request passes through the command queue, then the output register
// throughput: one transaction per cycle while responses are accepted, set by the single-port store
//   doing one push or one registered pop per cycle
// reset: clears shift state, pointers, command queue and output register;
//   the character store is not cleared and needs no clearing pass
module scancode_to_ascii_queue (
  input  logic        clk,
  input  logic        rst,
  sc2a_req_if.sink    req,
  sc2a_rsp_if.source  rsp
);

  logic            front_valid;
  sc2a_pkg::cmd_t  front_cmd;
  logic            front_ready;
  logic            back_valid;
  sc2a_pkg::cmd_t  back_cmd;
  logic            back_ready;

  sc2a_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (front_valid),
    .cmd       (front_cmd),
    .cmd_ready (front_ready)
  );

  sc2a_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_cmd    (front_cmd),
    .in_ready  (front_ready),
    .out_valid (back_valid),
    .out_cmd   (back_cmd),
    .out_ready (back_ready)
  );

  sc2a_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd       (back_cmd),
    .cmd_ready (back_ready),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  // a response reports at most one outcome
  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> $onehot0({rsp.char_valid, rsp.char_pushed, rsp.char_dropped}))
    else $error("response carries more than one outcome");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.char_valid) |-> (rsp.char_value == 7'h00))
    else $error("character value nonzero without a popped character");

  a_read_class: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.opcode == sc2a_pkg::OP_READ)
      |-> (front_cmd.op == sc2a_pkg::CMD_READ))
    else $error("read request not classified as a read");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> (!rsp.valid && !back_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule
